### rtl/core/fir_filter_centered_zero_pad_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the centered zero-pad FIR unit
// Shorthand for clocked implication checks with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_CENTERED_ZERO_PAD_UNIT_MACROS_SVH
`define FIR_FILTER_CENTERED_ZERO_PAD_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FZP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fzp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FZP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fzp: next-cycle check failed");

`endif

### rtl/core/fzp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fzp_pkg
// Shared types and constants of the centered zero-pad FIR unit.
// ----------------------------------------------------------------------------
package fzp_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int COEFF_W         = 16;
    localparam int PROD_W          = SAMPLE_W + COEFF_W;
    localparam int NUM_COEFF       = 7;
    localparam int TAP_COUNT_W     = 3;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int OFF_W           = 2;
    localparam int ROUND_SHIFT     = 14;
    localparam int DEF_MAX_TAPS    = 7;
    localparam int DEF_COUNT_WIDTH = 16;

    localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 3'd1;
    localparam logic signed [COEFF_W-1:0] COEFF_0_RESET = 16'sd16384;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TAP_COUNT,
        REG_COEFF_0,
        REG_COEFF_1,
        REG_COEFF_2,
        REG_COEFF_3,
        REG_COEFF_4,
        REG_COEFF_5,
        REG_COEFF_6
    } cfg_reg_t;

    typedef enum logic {
        ST_RUN,
        ST_FLUSH
    } seq_state_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       end_of_signal;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered;
        logic                       saturated;
        logic                       last_out;
    } result_t;

    // Control handed from the sequencer to every tap cell.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // Item tag that travels with the product set into the adder tree.
    typedef struct packed {
        logic valid;
        logic last;
    } tag_t;

endpackage

### rtl/core/fzp_tap_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fzp_tap_cell
// One history slot of the filter: holds a sample and forms its weighted product.
// ----------------------------------------------------------------------------
module fzp_tap_cell (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  fzp_pkg::cell_ctrl_t                  ctrl,
    input  logic signed [fzp_pkg::SAMPLE_W-1:0]  data_in,
    input  logic signed [fzp_pkg::COEFF_W-1:0]   weight,
    output logic signed [fzp_pkg::SAMPLE_W-1:0]  data_out,
    output logic signed [fzp_pkg::PROD_W-1:0]    product
);
    import fzp_pkg::*;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   mult;

    // Operands are sign-extended to the product width before the multiply.
    assign mult = data_in * weight;

    // The product is taken from the incoming sample, so a clear on the same
    // shift still lets the final item use the value that enters this slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            sample_reg <= ctrl.clear ? '0 : data_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            prod_reg <= mult;
        end
    end

    assign data_out = sample_reg;
    assign product  = prod_reg;

endmodule

### rtl/core/fzp_sum_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fzp_sum_tree
// Registered adder tree over the cell products, then round, shift and clip.
// ----------------------------------------------------------------------------
module fzp_sum_tree #(
    parameter int MAX_TAPS = fzp_pkg::DEF_MAX_TAPS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic signed [fzp_pkg::PROD_W-1:0]  prod [MAX_TAPS],
    input  fzp_pkg::tag_t                      tag,
    output logic                               ready,
    output logic                               out_valid,
    input  logic                               out_stall,
    output fzp_pkg::result_t                   out_data
);
    import fzp_pkg::*;

    localparam int LEAVES  = 8;
    localparam int A_W     = PROD_W + 1;
    localparam int B_W     = PROD_W + 2;
    localparam int ACC_W   = PROD_W + 3;
    localparam int SHIFT_W = ACC_W - ROUND_SHIFT;

    localparam logic signed [ACC_W-1:0]   ROUND_HALF = ACC_W'(1) <<< (ROUND_SHIFT - 1);
    localparam logic signed [SHIFT_W-1:0] POS_LIM    = SHIFT_W'(2 ** (SAMPLE_W - 1) - 1);
    localparam logic signed [SHIFT_W-1:0] NEG_LIM    = -SHIFT_W'(2 ** (SAMPLE_W - 1));

    logic signed [PROD_W-1:0] leaf [LEAVES];
    logic signed [A_W-1:0]    sa_reg [LEAVES/2];
    logic signed [B_W-1:0]    sb_reg [LEAVES/4];
    logic                     va_reg, la_reg, vb_reg, lb_reg, vo_reg;
    result_t                  out_reg;
    result_t                  out_next;
    logic                     ready_a, ready_b, ready_o;

    logic signed [ACC_W-1:0]   total;
    logic signed [ACC_W-1:0]   rounded;
    logic signed [SHIFT_W-1:0] shifted;

    for (genvar i = 0; i < LEAVES; i++)
    begin : g_leaf
        if (i < MAX_TAPS)
        begin : g_used
            assign leaf[i] = prod[i];
        end
        else
        begin : g_pad
            assign leaf[i] = '0;
        end
    end

    // Each level moves when its successor is empty or moving.
    assign ready_o = !vo_reg || !out_stall;
    assign ready_b = !vb_reg || ready_o;
    assign ready_a = !va_reg || ready_b;
    assign ready   = ready_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            la_reg <= 1'b0;
            vb_reg <= 1'b0;
            lb_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                va_reg <= tag.valid;
                la_reg <= tag.last;
            end
            if (ready_b)
            begin
                vb_reg <= va_reg;
                lb_reg <= la_reg;
            end
            if (ready_o)
            begin
                vo_reg <= vb_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a)
        begin
            for (int i = 0; i < LEAVES / 2; i++)
            begin
                sa_reg[i] <= A_W'(leaf[2*i]) + A_W'(leaf[2*i+1]);
            end
        end
        if (ready_b)
        begin
            for (int i = 0; i < LEAVES / 4; i++)
            begin
                sb_reg[i] <= B_W'(sa_reg[2*i]) + B_W'(sa_reg[2*i+1]);
            end
        end
        if (ready_o)
        begin
            out_reg <= out_next;
        end
    end

    // Round half up, floor shift, then clip to the sample range.
    always_comb
    begin
        total   = ACC_W'(sb_reg[0]) + ACC_W'(sb_reg[1]);
        rounded = total + ROUND_HALF;
        shifted = $signed(rounded[ACC_W-1:ROUND_SHIFT]);
        out_next.last_out = lb_reg;
        if (shifted > POS_LIM)
        begin
            out_next.filtered  = POS_LIM[SAMPLE_W-1:0];
            out_next.saturated = 1'b1;
        end
        else if (shifted < NEG_LIM)
        begin
            out_next.filtered  = NEG_LIM[SAMPLE_W-1:0];
            out_next.saturated = 1'b1;
        end
        else
        begin
            out_next.filtered  = shifted[SAMPLE_W-1:0];
            out_next.saturated = 1'b0;
        end
    end

    assign out_valid = vo_reg;
    assign out_data  = out_reg;

endmodule

### rtl/core/fir_filter_centered_zero_pad_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_centered_zero_pad_unit
// Streaming centered FIR correlation with zero padding at both signal ends.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake                   Payload
// sample   in   sample_valid / sample_stall fzp_pkg::in_item_t
// result   out  result_valid / result_stall fzp_pkg::result_t
// config   in   cfg_we (write only)         cfg_index, cfg_data
//
// One sample item is taken every clock while the result side keeps moving
// and no flush is under way. A sample that closes a signal starts a flush:
// k zero samples (k = taps in use / 2, at most 3) are pushed down the cell
// chain with the sample side stalled, to flush the pending outputs.
// Each accepted sample item loads the cell products on the accepting edge,
// then passes through two adder levels and the rounding output register.
// result_stall backs up the pipeline level by level; outside a flush,
// sample_stall rises only once every level up to the cells is full.
// Reset is asynchronous; it clears history and count and restores the
// configuration defaults at once. There is no clearing pass.
// ----------------------------------------------------------------------------
`include "fir_filter_centered_zero_pad_unit_macros.svh"

module fir_filter_centered_zero_pad_unit #(
    parameter int MAX_TAPS    = fzp_pkg::DEF_MAX_TAPS,
    parameter int COUNT_WIDTH = fzp_pkg::DEF_COUNT_WIDTH
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    sample_valid,
    output logic                                    sample_stall,
    input  fzp_pkg::in_item_t                       sample_data,
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output fzp_pkg::result_t                        result_data,
    input  logic                                    cfg_we,
    input  logic [fzp_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [fzp_pkg::CFG_DATA_W-1:0]          cfg_data
);
    import fzp_pkg::*;

    localparam int MAX_OFF = MAX_TAPS / 2;

    // Configuration registers.
    logic [TAP_COUNT_W-1:0]     tap_count_reg;
    logic signed [COEFF_W-1:0]  coeff_reg [NUM_COEFF];

    // Sequencer state.
    seq_state_t                 state_reg, state_next;
    logic [OFF_W-1:0]           zeros_left_reg, zeros_left_next;
    logic [COUNT_WIDTH-1:0]     count_reg, count_next, count_inc;

    // Tag for the product set held in the cells.
    logic                       p_valid_reg, p_last_reg;

    logic [TAP_COUNT_W-1:0]     taps;
    logic [OFF_W-1:0]           off;
    logic [COUNT_WIDTH-1:0]     count_off;
    logic                       emit;
    logic                       item_last;
    logic                       ready_p;
    logic                       tree_ready;
    cell_ctrl_t                 cell_ctrl;
    tag_t                       p_tag;
    logic signed [SAMPLE_W-1:0] head_sample;
    logic signed [SAMPLE_W-1:0] cell_in   [MAX_TAPS];
    logic signed [COEFF_W-1:0]  weight    [MAX_TAPS];
    logic signed [PROD_W-1:0]   cell_prod [MAX_TAPS];

    // Sequencer events watched by the checks at the end.
    logic                       flush_start;
    logic                       flush_done;
    logic                       in_flush;

    // ------------------------------------------------------------------
    // Configuration writes. Index 0 is the tap count, the rest are the
    // coefficients in order.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_COUNT_RESET;
            coeff_reg[0]  <= COEFF_0_RESET;
            for (int i = 1; i < NUM_COEFF; i++)
            begin
                coeff_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_TAP_COUNT)
            begin
                tap_count_reg <= cfg_data[TAP_COUNT_W-1:0];
            end
            else
            begin
                coeff_reg[CFG_INDEX_W'(cfg_index - REG_COEFF_0)] <= $signed(cfg_data);
            end
        end
    end

    // A tap count of zero means one tap; anything above the cell count is
    // clamped to it. The centering offset is half the taps in use.
    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            taps = TAP_COUNT_W'(1);
        end
        else if (tap_count_reg > TAP_COUNT_W'(MAX_TAPS))
        begin
            taps = TAP_COUNT_W'(MAX_TAPS);
        end
        else
        begin
            taps = tap_count_reg;
        end
    end

    assign off       = taps[TAP_COUNT_W-1:1];
    assign count_off = COUNT_WIDTH'(off);
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + COUNT_WIDTH'(1);

    // ------------------------------------------------------------------
    // Per-cell weight. Cell d holds the sample d steps back, which meets
    // coefficient 2*off - d for the output that is due now. Cells outside
    // the kernel get a zero weight.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < MAX_TAPS; g++)
    begin : g_weight
        always_comb
        begin
            weight[g] = '0;
            for (int o = 0; o <= MAX_OFF; o++)
            begin
                if (off == OFF_W'(o) && 2 * o >= g && 2 * o - g < int'(taps))
                begin
                    weight[g] = coeff_reg[2 * o - g];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer. In RUN each accepted sample shifts the chain. A sample
    // that ends the signal is itself the last push if the offset is zero;
    // else it switches to FLUSH, which pushes one zero per cycle while not
    // stalled until all pending outputs have been issued. The last push
    // clears the history and the sample count. An output is due whenever
    // the running count has reached the offset; the zero pushes keep counting
    // so that a short signal still yields exactly one output per sample.
    // ------------------------------------------------------------------
    assign ready_p = !p_valid_reg || tree_ready;

    always_comb
    begin
        state_next      = state_reg;
        zeros_left_next = zeros_left_reg;
        count_next      = count_reg;
        cell_ctrl       = '0;
        head_sample     = sample_data.sample;
        sample_stall    = !ready_p;
        item_last       = 1'b0;
        emit            = (count_reg >= count_off);
        case (state_reg)
            ST_RUN:
            begin
                cell_ctrl.shift = sample_valid && ready_p;
                if (cell_ctrl.shift)
                begin
                    if (sample_data.end_of_signal)
                    begin
                        if (off == '0)
                        begin
                            item_last       = 1'b1;
                            cell_ctrl.clear = 1'b1;
                            count_next      = '0;
                        end
                        else
                        begin
                            state_next      = ST_FLUSH;
                            zeros_left_next = off;
                            count_next      = count_inc;
                        end
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
            end
            ST_FLUSH:
            begin
                sample_stall    = 1'b1;
                head_sample     = '0;
                cell_ctrl.shift = ready_p;
                if (ready_p)
                begin
                    zeros_left_next = zeros_left_reg - OFF_W'(1);
                    count_next      = count_inc;
                    if (zeros_left_reg == OFF_W'(1))
                    begin
                        item_last       = 1'b1;
                        cell_ctrl.clear = 1'b1;
                        count_next      = '0;
                        state_next      = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            zeros_left_reg <= '0;
            count_reg      <= '0;
            p_valid_reg    <= 1'b0;
            p_last_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            zeros_left_reg <= zeros_left_next;
            count_reg      <= count_next;
            if (ready_p)
            begin
                p_valid_reg <= cell_ctrl.shift && emit;
                p_last_reg  <= item_last;
            end
        end
    end

    // ------------------------------------------------------------------
    // Cell chain: cell 0 takes the new sample (or a flush zero), every
    // other cell takes its neighbor's sample on each shift; a clear zeroes them all.
    // ------------------------------------------------------------------
    assign cell_in[0] = head_sample;

    for (genvar g = 0; g < MAX_TAPS; g++)
    begin : g_cell
        if (g < MAX_TAPS - 1)
        begin : g_mid
            fzp_tap_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl),
                .data_in  (cell_in[g]),
                .weight   (weight[g]),
                .data_out (cell_in[g+1]),
                .product  (cell_prod[g])
            );
        end
        else
        begin : g_end
            fzp_tap_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl),
                .data_in  (cell_in[g]),
                .weight   (weight[g]),
                .data_out (),
                .product  (cell_prod[g])
            );
        end
    end

    assign p_tag.valid = p_valid_reg;
    assign p_tag.last  = p_last_reg;

    fzp_sum_tree #(
        .MAX_TAPS (MAX_TAPS)
    ) u_sum_tree (
        .clk       (clk),
        .rst_n     (rst_n),
        .prod      (cell_prod),
        .tag       (p_tag),
        .ready     (tree_ready),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_data  (result_data)
    );

    // ------------------------------------------------------------------
    // Checks on the sequencer.
    // ------------------------------------------------------------------
    assign flush_start = sample_valid && !sample_stall && sample_data.end_of_signal && off != '0;
    assign flush_done  = state_reg == ST_FLUSH && ready_p && zeros_left_reg == OFF_W'(1);
    assign in_flush    = state_reg == ST_FLUSH;

    `FZP_ASSERT_NEXT(a_flush_entry, clk, rst_n, flush_start, in_flush && zeros_left_reg == $past(off))
    `FZP_ASSERT_NEXT(a_flush_exit, clk, rst_n, flush_done, state_reg == ST_RUN && count_reg == '0)
    `FZP_ASSERT_IMPLY(a_flush_pending, clk, rst_n, in_flush, zeros_left_reg != '0 && sample_stall)

endmodule

### tb/fir_filter_centered_zero_pad_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_centered_zero_pad_unit_test
// Self-checking bench for the centered zero-pad FIR unit. Sample items come
// from a queue through a driver with random gaps, and a monitor stalls the
// result side at random. A behavioral filter computes the expected results of
// every accepted sample. The monitor compares each result with the oldest
// expected one. Registers are reprogrammed only while the unit is quiet.
// ----------------------------------------------------------------------------
module fir_filter_centered_zero_pad_unit_test;

    import fzp_pkg::*;

    // Quiet wait after each drain that lets the unit come to rest: results
    // still in the pipeline and the flush pushes after a closing sample finish.
    localparam int SETTLE_CYCLES = 12;
    // Cycles with no item moving on either side before the run is abandoned.
    localparam int QUIET_LIMIT   = 2000;
    localparam int COUNT_MAX     = (1 << DEF_COUNT_WIDTH) - 1;
    localparam int BURST_ITEMS   = 8;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 12;
    localparam longint RESULT_HI = 32767;
    localparam longint RESULT_LO = -32768;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              sample_valid = 1'b0;
    logic              sample_stall;
    in_item_t          sample_data = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    result_t           result_data;
    logic              cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_TAP_COUNT;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Stimulus and scoreboard state.
    in_item_t pending_samples[$];
    result_t  expected_results[$];
    result_t  oldest_expected;
    int       queued_total = 0;
    int       accepted_total = 0;
    int       error_count = 0;
    int       quiet_cycles = 0;
    int       gap_left = 0;
    int       stall_left = 0;
    bit       gaps_on = 1'b1;
    bit       sample_taken = 1'b0;
    bit       result_taken = 1'b0;

    // The behavioral filter keeps its own copy of the registers, the sample
    // history (newest first) and the position within the current signal.
    logic [TAP_COUNT_W-1:0]     taps_setting = TAP_COUNT_RESET;
    logic signed [COEFF_W-1:0]  coeff_setting [NUM_COEFF];
    logic signed [SAMPLE_W-1:0] history [DEF_MAX_TAPS];
    int                         sample_count = 0;

    fir_filter_centered_zero_pad_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // One output position of the correlation. Taps that land before the
    // first sample or after the newest one read zero, which gives the zero
    // padding at both ends of the signal.
    function automatic result_t tap_sum(input int pos, input int newest, input int taps,
                                        input int off, input logic closing);
        longint  acc;
        int      idx;
        int      j;
        result_t r;
        acc = 0;
        for (j = 0; j < taps; j++)
        begin
            idx = pos + j - off;
            if (idx >= 0 && idx <= newest && newest - idx < DEF_MAX_TAPS)
                acc += longint'(coeff_setting[j]) * longint'(history[newest - idx]);
        end
        // Round half up, then an arithmetic shift floors the Q2.14 scaling away.
        acc = (acc + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        r.saturated = (acc > RESULT_HI) || (acc < RESULT_LO);
        if (acc > RESULT_HI)
            acc = RESULT_HI;
        else if (acc < RESULT_LO)
            acc = RESULT_LO;
        r.filtered = acc[SAMPLE_W-1:0];
        r.last_out = closing;
        return r;
    endfunction

    // Advance the behavioral filter by one accepted sample item and queue the
    // results that it releases.
    task automatic filter_sample(input in_item_t item);
        int taps;
        int off;
        int newest;
        int pos;
        int d;
        // A tap count of zero still means one tap.
        taps = (taps_setting == 0) ? 1 : int'(taps_setting);
        if (taps > DEF_MAX_TAPS)
            taps = DEF_MAX_TAPS;
        off = taps / 2;
        newest = sample_count;
        for (d = DEF_MAX_TAPS - 1; d > 0; d--)
            history[d] = history[d - 1];
        history[0] = item.sample;
        if (!item.end_of_signal)
        begin
            // Output i waits for sample i + off, so the first off samples
            // of a signal release nothing.
            if (newest >= off)
                expected_results.push_back(tap_sum(newest - off, newest, taps, off, 1'b0));
            // The count sticks at its maximum; only short distances matter.
            if (sample_count < COUNT_MAX)
                sample_count++;
        end
        else
        begin
            // The closing sample flushes every pending position. A signal
            // shorter than the offset starts its flush at position zero.
            pos = (newest > off) ? newest - off : 0;
            while (pos <= newest)
            begin
                expected_results.push_back(tap_sum(pos, newest, taps, off, pos == newest));
                pos++;
            end
            for (d = 0; d < DEF_MAX_TAPS; d++)
                history[d] = '0;
            sample_count = 0;
        end
    endtask

    function automatic int draw_wait();
        return gaps_on ? int'($urandom_range(0, 11)) : 0;
    endfunction

    // Values for samples and coefficients, with the extremes drawn often.
    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        $display("%0t ns: %s", $time, msg);
    endtask

    task automatic queue_sample(input logic [SAMPLE_W-1:0] value, input logic closing);
        in_item_t item;
        item.sample = value;
        item.end_of_signal = closing;
        pending_samples.push_back(item);
        queued_total++;
    endtask

    // Register write. It is only called while the unit is quiet, so the
    // filter copy can take the new value at once.
    task automatic set_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == REG_TAP_COUNT)
            taps_setting = value[TAP_COUNT_W-1:0];
        else
            coeff_setting[idx - REG_COEFF_0] = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Holds the sender back until every queued item has gone in and every
    // expected result has come out, then lets the unit settle. This is also
    // needed after items that release no result, since the unit may still
    // be shifting them along.
    task automatic drain();
        do
            @(negedge clk);
        while (accepted_total != queued_total || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Sample side, rising edge: an item moves when valid is high and stall
    // is low. The filter copy is advanced right here.
    always @(posedge clk)
    begin
        sample_taken = rst_n && sample_valid && !sample_stall;
        if (sample_taken)
        begin
            filter_sample(sample_data);
            accepted_total++;
        end
    end

    // Sample side driver, falling edge. A stalled item is held unchanged.
    // After each accepted item a fresh gap is drawn before the next one.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sample_taken)
                gap_left = draw_wait();
            if (sample_valid && !sample_taken)
                sample_valid <= 1'b1;
            else if (gap_left > 0)
            begin
                sample_valid <= 1'b0;
                gap_left--;
            end
            else if (pending_samples.size() != 0)
            begin
                sample_valid <= 1'b1;
                sample_data <= pending_samples.pop_front();
            end
            else
                sample_valid <= 1'b0;
        end
    end

    // Result side monitor, rising edge: each accepted result is checked
    // field by field against the oldest expectation.
    always @(posedge clk)
    begin
        result_taken = rst_n && result_valid && !result_stall;
        if (result_taken)
        begin
            if (expected_results.size() == 0)
                note_error($sformatf("unexpected result: expected none, got %0d/%0b/%0b",
                                     result_data.filtered, result_data.saturated,
                                     result_data.last_out));
            else
            begin
                oldest_expected = expected_results.pop_front();
                if (result_data.filtered !== oldest_expected.filtered)
                    note_error($sformatf("filtered: expected %0d, got %0d",
                                         oldest_expected.filtered, result_data.filtered));
                if (result_data.saturated !== oldest_expected.saturated)
                    note_error($sformatf("saturated: expected %0b, got %0b",
                                         oldest_expected.saturated, result_data.saturated));
                if (result_data.last_out !== oldest_expected.last_out)
                    note_error($sformatf("last_out: expected %0b, got %0b",
                                         oldest_expected.last_out, result_data.last_out));
            end
        end
    end

    // Result side stall, falling edge: after each accepted result the
    // receiver stalls for a freshly drawn number of cycles.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_taken)
                stall_left = draw_wait();
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // Watchdog: ends the run when neither side has moved an item for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("fir_filter_centered_zero_pad_unit_test failed");
                $finish;
            end
        end
    end

    initial
    begin
        int k;
        int ph;
        for (k = 0; k < NUM_COEFF; k++)
            coeff_setting[k] = '0;
        coeff_setting[0] = COEFF_0_RESET;
        for (k = 0; k < DEF_MAX_TAPS; k++)
            history[k] = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings give one tap of unity gain: the extremes pass through.
        queue_sample(16'h7fff, 1'b0);
        queue_sample(16'h8000, 1'b0);
        queue_sample(16'h0001, 1'b0);
        queue_sample(16'hffff, 1'b1);
        drain();

        // A tap count of zero acts as one tap. With a gain of -2 the most
        // negative sample overflows, half scale lands exactly on the bottom,
        // and a signal of a single sample yields one closing output.
        set_reg(REG_TAP_COUNT, 16'd0);
        set_reg(REG_COEFF_0, 16'h8000);
        queue_sample(16'h4000, 1'b0);
        queue_sample(16'hc000, 1'b0);
        queue_sample(16'h8000, 1'b1);
        queue_sample(16'h0000, 1'b1);
        drain();

        // All seven taps at full positive weight drive the sum far past both
        // rails. The first signal is shorter than the offset.
        set_reg(REG_TAP_COUNT, 16'd7);
        for (k = 0; k < NUM_COEFF; k++)
            set_reg(cfg_reg_t'(REG_COEFF_0 + k), 16'h7fff);
        queue_sample(16'h7fff, 1'b0);
        queue_sample(16'h7fff, 1'b1);
        for (k = 0; k < 4; k++)
            queue_sample(16'h8000, 1'b0);
        queue_sample(16'h8000, 1'b1);
        queue_sample(16'd12345, 1'b1);
        drain();

        // Registers rewritten in the middle of a signal: the offset grows
        // from one to three, so some output positions come out twice.
        set_reg(REG_TAP_COUNT, 16'd2);
        set_reg(REG_COEFF_0, 16'h4000);
        set_reg(REG_COEFF_1, 16'hc000);
        for (k = 0; k < 3; k++)
            queue_sample(pick_value(), 1'b0);
        drain();
        set_reg(REG_TAP_COUNT, 16'd6);
        queue_sample(pick_value(), 1'b0);
        queue_sample(pick_value(), 1'b0);
        queue_sample(pick_value(), 1'b1);
        drain();

        // A signal streamed back to back with no gaps and no stalls.
        gaps_on = 1'b0;
        set_reg(REG_TAP_COUNT, 16'd7);
        for (k = 0; k < NUM_COEFF; k++)
            set_reg(cfg_reg_t'(REG_COEFF_0 + k), pick_value());
        for (k = 0; k < BURST_ITEMS - 1; k++)
            queue_sample(pick_value(), 1'b0);
        queue_sample(pick_value(), 1'b1);
        drain();

        // Random phases: fresh settings each time, signals of random length
        // with random content. A signal left open at the end of a phase sees
        // its registers change before it closes.
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            set_reg(REG_TAP_COUNT, CFG_DATA_W'($urandom_range(0, 7)));
            for (k = 0; k < NUM_COEFF; k++)
                set_reg(cfg_reg_t'(REG_COEFF_0 + k), pick_value());
            for (k = 0; k < PHASE_ITEMS; k++)
                queue_sample(pick_value(), $urandom_range(0, 4) == 0);
            drain();
        end
        queue_sample(pick_value(), 1'b1);
        drain();

        if (error_count == 0)
            $display("fir_filter_centered_zero_pad_unit_test passed");
        else
            $display("fir_filter_centered_zero_pad_unit_test failed");
        $finish;
    end

endmodule
